FILE: rtl/core/ise_pkg.sv
// Shared types and constants for the indexed stack engine.
`timescale 1ns / 1ps

package ise_pkg;

	localparam int ISE_DEPTH      = 16;
	localparam int ISE_DATA_WIDTH = 32;
	localparam int ACT_W          = 3;
	localparam int CFG_W          = 5;
	localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_INSERT = 3'd2,
		ACT_DELETE = 3'd3,
		ACT_SWAP   = 3'd4,
		ACT_READ   = 3'd5
	} ise_action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_RANGE     = 2'd3
	} ise_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EVAL,
		S_SH_RD,
		S_SH_WR,
		S_SW_RB,
		S_SW_WA,
		S_SW_WB,
		S_RD_WAIT,
		S_FINISH
	} ise_state_t;

	typedef enum logic [1:0] {
		WSEL_ELEM,
		WSEL_RDATA,
		WSEL_TMP
	} ise_wsel_t;

	typedef struct packed {
		logic      rd_en;
		logic      wr_en;
		ise_wsel_t wsel;
	} ise_mem_ctl_t;

	typedef struct packed {
		logic        valid;
		ise_status_t status;
	} ise_res_t;

endpackage

FILE: rtl/core/indexed_stack_engine.sv
// Channel   Handshake          Payload
// input     in_valid/in_stall  action, element_in, index_a, index_b
// output    out_valid/out_stall read_data, status, entry_count
// config    cfg_write_en       cfg_write_data (capacity limit)
//
// One request at a time; in_stall is high from acceptance until the result
// enters the output register. Insert and delete move one entry at a time,
// reading it and then writing it, as memory reads and writes never overlap.
// Reset clears the count and control; entry storage is not cleared.
// A held result on a stalled output does not block the next request's work.
`timescale 1ns / 1ps

module indexed_stack_engine import ise_pkg::*; #(
	parameter int DEPTH      = ISE_DEPTH,
	parameter int DATA_WIDTH = ISE_DATA_WIDTH,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACT_W-1:0]      action,
	input  logic [DATA_WIDTH-1:0] element_in,
	input  logic [IDX_W-1:0]      index_a,
	input  logic [IDX_W-1:0]      index_b,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] read_data,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      entry_count,
	input  logic                  cfg_write_en,
	input  logic [CFG_W-1:0]      cfg_write_data
);

	logic [CFG_W-1:0]      cap_q;
	logic                  idle;
	logic                  res_take;
	ise_res_t              res;
	logic [CNT_W-1:0]      res_count;
	logic [DATA_WIDTH-1:0] res_rdata;
	ise_mem_ctl_t          mem_ctl;
	logic [IDX_W-1:0]      rd_addr, wr_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] read_data_q;
	ise_status_t           status_q;
	logic [CNT_W-1:0]      entry_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			cap_q <= cfg_write_data;
		end
	end

	ise_seq #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.idle       (idle),
		.action     (action),
		.element_in (element_in),
		.index_a    (index_a),
		.index_b    (index_b),
		.capacity   (cap_q),
		.res_take   (res_take),
		.res        (res),
		.res_count  (res_count),
		.res_rdata  (res_rdata),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_data    (rd_data)
	);

	ise_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem_ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (mem_ctl.wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign in_stall = !idle;

	// Output register: load when empty or being drained this cycle.
	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			read_data_q   <= res_rdata;
			status_q      <= res.status;
			entry_count_q <= res_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

endmodule

FILE: rtl/core/ise_ram.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ise_ram import ise_pkg::*; #(
	parameter int DEPTH      = ISE_DEPTH,
	parameter int DATA_WIDTH = ISE_DATA_WIDTH,
	localparam int IDX_W     = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [DATA_WIDTH-1:0] rd_data,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/core/ise_seq.sv
// Request sequencer: checks, pointer stepping and memory moves for one request.
`timescale 1ns / 1ps

module ise_seq import ise_pkg::*; #(
	parameter int DEPTH      = ISE_DEPTH,
	parameter int DATA_WIDTH = ISE_DATA_WIDTH,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  idle,
	input  logic [ACT_W-1:0]      action,
	input  logic [DATA_WIDTH-1:0] element_in,
	input  logic [IDX_W-1:0]      index_a,
	input  logic [IDX_W-1:0]      index_b,
	input  logic [CFG_W-1:0]      capacity,
	input  logic                  res_take,
	output ise_res_t              res,
	output logic [CNT_W-1:0]      res_count,
	output logic [DATA_WIDTH-1:0] res_rdata,
	output ise_mem_ctl_t          mem_ctl,
	output logic [IDX_W-1:0]      rd_addr,
	output logic [IDX_W-1:0]      wr_addr,
	output logic [DATA_WIDTH-1:0] wr_data,
	input  logic [DATA_WIDTH-1:0] rd_data
);

	localparam int CW = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	ise_state_t            state_q, state_d;
	ise_action_t           act_q;
	logic [DATA_WIDTH-1:0] elem_q;
	logic [IDX_W-1:0]      ia_q, ib_q;
	logic [CNT_W-1:0]      n_q, n_d;
	logic [CNT_W-1:0]      ptr_q, ptr_d;
	logic [DATA_WIDTH-1:0] tmp_q, tmp_d;
	logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
	ise_status_t           status_q, status_d;

	logic [CNT_W-1:0] n_inc, n_dec, ptr_src;
	logic [CW-1:0]    n_x, ia_x, ib_x, cap_x, dep_x, cap_eff;
	logic             accept;

	assign idle   = (state_q == S_IDLE);
	assign accept = idle && in_valid;

	// Shared step unit: insert walks down from the top, delete walks up.
	assign ptr_src = (act_q == ACT_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
	assign n_inc   = n_q + 1'b1;
	assign n_dec   = n_q - 1'b1;

	assign n_x     = CW'(n_q);
	assign ia_x    = CW'(ia_q);
	assign ib_x    = CW'(ib_q);
	assign cap_x   = CW'(capacity);
	assign dep_x   = CW'(DEPTH);
	assign cap_eff = (cap_x > dep_x) ? dep_x : cap_x;

	always_comb begin
		state_d       = state_q;
		n_d           = n_q;
		ptr_d         = ptr_q;
		tmp_d         = tmp_q;
		rdata_d       = rdata_q;
		status_d      = status_q;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		mem_ctl.wsel  = WSEL_ELEM;
		rd_addr       = ia_q;
		wr_addr       = ia_q;
		res.valid     = 1'b0;
		res.status    = status_q;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				status_d = ST_OK;
				rdata_d  = '0;
				state_d  = S_FINISH;
				unique case (act_q)
					ACT_PUSH: begin
						if (n_x >= cap_eff) begin
							status_d = ST_OVERFLOW;
						end else begin
							mem_ctl.wr_en = 1'b1;
							wr_addr       = n_q[IDX_W-1:0];
							n_d           = n_inc;
						end
					end
					ACT_POP: begin
						if (n_q == '0) begin
							status_d = ST_UNDERFLOW;
						end else begin
							mem_ctl.rd_en = 1'b1;
							rd_addr       = n_dec[IDX_W-1:0];
							n_d           = n_dec;
							state_d       = S_RD_WAIT;
						end
					end
					ACT_INSERT: begin
						if (n_x >= cap_eff) begin
							status_d = ST_OVERFLOW;
						end else if (ia_x > n_x) begin
							status_d = ST_RANGE;
						end else begin
							ptr_d   = n_q;
							state_d = S_SH_RD;
						end
					end
					ACT_DELETE: begin
						if (n_q == '0) begin
							status_d = ST_UNDERFLOW;
						end else if (ia_x >= n_x) begin
							status_d = ST_RANGE;
						end else begin
							ptr_d   = CNT_W'(ia_q);
							state_d = S_SH_RD;
						end
					end
					ACT_SWAP: begin
						if (ia_x >= n_x || ib_x >= n_x) begin
							status_d = ST_RANGE;
						end else begin
							mem_ctl.rd_en = 1'b1;
							state_d       = S_SW_RB;
						end
					end
					ACT_READ: begin
						if (ia_x >= n_x) begin
							status_d = ST_RANGE;
						end else begin
							mem_ctl.rd_en = 1'b1;
							state_d       = S_RD_WAIT;
						end
					end
					default: ;
				endcase
			end
			S_SH_RD: begin
				if (act_q == ACT_INSERT && ptr_q == CNT_W'(ia_q)) begin
					mem_ctl.wr_en = 1'b1;
					n_d           = n_inc;
					state_d       = S_FINISH;
				end else if (act_q != ACT_INSERT && ptr_src == n_q) begin
					n_d     = n_dec;
					state_d = S_FINISH;
				end else begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = ptr_src[IDX_W-1:0];
					state_d       = S_SH_WR;
				end
			end
			S_SH_WR: begin
				mem_ctl.wr_en = 1'b1;
				mem_ctl.wsel  = WSEL_RDATA;
				wr_addr       = ptr_q[IDX_W-1:0];
				ptr_d         = ptr_src;
				state_d       = S_SH_RD;
			end
			S_SW_RB: begin
				tmp_d         = rd_data;
				mem_ctl.rd_en = 1'b1;
				rd_addr       = ib_q;
				state_d       = S_SW_WA;
			end
			S_SW_WA: begin
				mem_ctl.wr_en = 1'b1;
				mem_ctl.wsel  = WSEL_RDATA;
				state_d       = S_SW_WB;
			end
			S_SW_WB: begin
				mem_ctl.wr_en = 1'b1;
				mem_ctl.wsel  = WSEL_TMP;
				wr_addr       = ib_q;
				state_d       = S_FINISH;
			end
			S_RD_WAIT: begin
				rdata_d = rd_data;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				res.valid = 1'b1;
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (mem_ctl.wsel)
			WSEL_RDATA: wr_data = rd_data;
			WSEL_TMP:   wr_data = tmp_q;
			default:    wr_data = elem_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= ise_action_t'(action);
			elem_q <= element_in;
			ia_q   <= index_a;
			ib_q   <= index_b;
		end
		ptr_q    <= ptr_d;
		tmp_q    <= tmp_d;
		rdata_q  <= rdata_d;
		status_q <= status_d;
	end

	assign res_count = n_q;
	assign res_rdata = rdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, n_q} <= (CNT_W + 1)'(DEPTH))
		else $error("entry count beyond depth");

	a_one_port_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.rd_en && mem_ctl.wr_en))
		else $error("memory read and write in the same cycle");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SH_WR |-> $past(state_q) == S_SH_RD)
		else $error("shift write without a preceding read");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL && status_d != ST_OK) |=> n_q == $past(n_q))
		else $error("failed request changed the entry count");

endmodule
